FILE: hw/rtl/utf8_to_utf16_decoder_core_assert.svh
// assertion macros for the utf-8 to utf-16 decoder core
`ifndef UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge once out of reset
`define U8U16_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8u16 assertion failed");
// property checked on every clock edge, reset included
`define U8U16_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT(lbl, prop)
`define U8U16_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hw/rtl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

    localparam int UnitW      = 16;
    localparam int PointW     = 21;
    localparam int MaxResults = 4;
    localparam int CntW       = $clog2(MaxResults + 1);

    localparam logic [UnitW-1:0]  ReplChar  = 16'hFFFD;
    localparam logic [UnitW-1:0]  SurHi     = 16'hD800;
    localparam logic [UnitW-1:0]  SurLo     = 16'hDC00;
    localparam logic [PointW-1:0] BmpMax    = 21'h00FFFF;
    localparam logic [PointW-1:0] MaxPoint  = 21'h10FFFF;
    localparam logic [PointW-1:0] PlaneBase = 21'h010000;

    typedef logic [UnitW-1:0] unit_t;

    // words produced by one input byte, entry 0 goes out first
    typedef struct packed {
        logic [MaxResults-1:0][UnitW-1:0] units;
        logic [CntW-1:0]                  count;
    } dec_res_t;

endpackage

FILE: hw/rtl/u8u16_decode.sv
// sequence state and single-pass decode of one utf-8 byte
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_text,
    output u8u16_pkg::dec_res_t res
);

    logic [1:0]                       expected_reg, expected_next;
    logic [1:0]                       taken_reg, taken_next;
    logic [u8u16_pkg::PointW-1:0]     point_reg, point_next;

    logic                             is_open, is_cont;
    logic [1:0]                       taken_inc;
    logic [u8u16_pkg::PointW-1:0]     point_acc;
    logic [u8u16_pkg::PointW-1:0]     plane_off;
    logic [u8u16_pkg::CntW-1:0]       n_repl;
    logic [1:0]                       n_tail;
    u8u16_pkg::unit_t                 tail0, tail1;

    always_comb
    begin
        is_open   = (expected_reg != 2'd0);
        is_cont   = (data_byte[7:6] == 2'b10);
        taken_inc = taken_reg + 2'd1;
        point_acc = {point_reg[u8u16_pkg::PointW-7:0], data_byte[5:0]};
        plane_off = point_acc - u8u16_pkg::PlaneBase;

        expected_next = 2'd0;
        taken_next    = 2'd0;
        point_next    = '0;
        n_repl        = '0;
        n_tail        = 2'd0;
        tail0         = u8u16_pkg::ReplChar;
        tail1         = u8u16_pkg::ReplChar;

        if (is_open && is_cont)
        begin
            if (taken_inc >= expected_reg)
            begin
                if (point_acc <= u8u16_pkg::BmpMax)
                begin
                    n_tail = 2'd1;
                    tail0  = point_acc[u8u16_pkg::UnitW-1:0];
                end
                else if (point_acc <= u8u16_pkg::MaxPoint)
                begin
                    n_tail = 2'd2;
                    tail0  = u8u16_pkg::SurHi | {6'd0, plane_off[19:10]};
                    tail1  = u8u16_pkg::SurLo | {6'd0, plane_off[9:0]};
                end
                else
                begin
                    n_tail = 2'd1;
                end
            end
            else if (end_of_text)
            begin
                n_repl = u8u16_pkg::CntW'(taken_inc) + u8u16_pkg::CntW'(1);
            end
            else
            begin
                expected_next = expected_reg;
                taken_next    = taken_inc;
                point_next    = point_acc;
            end
        end
        else
        begin
            // if open, broken: lead plus taken continuations, then the byte as a lead
            if (is_open)
            begin
                n_repl = u8u16_pkg::CntW'(taken_reg) + u8u16_pkg::CntW'(1);
            end
            priority if (data_byte[7] == 1'b0)
            begin
                n_tail = 2'd1;
                tail0  = {8'd0, data_byte};
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                expected_next = 2'd1;
                point_next    = u8u16_pkg::PointW'(data_byte[4:0]);
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                expected_next = 2'd2;
                point_next    = u8u16_pkg::PointW'(data_byte[3:0]);
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                expected_next = 2'd3;
                point_next    = u8u16_pkg::PointW'(data_byte[2:0]);
            end
            else
            begin
                n_tail = 2'd1;
            end
            // a lead byte that ends the text closes at once
            if (end_of_text && (expected_next != 2'd0))
            begin
                n_repl        = n_repl + u8u16_pkg::CntW'(1);
                expected_next = 2'd0;
                point_next    = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < u8u16_pkg::MaxResults; i++)
        begin
            if (u8u16_pkg::CntW'(i) < n_repl)
                res.units[i] = u8u16_pkg::ReplChar;
            else if (u8u16_pkg::CntW'(i) == n_repl)
                res.units[i] = tail0;
            else
                res.units[i] = tail1;
        end
        res.count = n_repl + u8u16_pkg::CntW'(n_tail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 2'd0;
            taken_reg    <= 2'd0;
            point_reg    <= '0;
        end
        else if (accept)
        begin
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
            point_reg    <= point_next;
        end
    end

endmodule

FILE: hw/rtl/u8u16_outbuf.sv
// result register that hands out the words of one byte one per cycle while m_tready is high
module u8u16_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u8u16_pkg::dec_res_t res,
    output logic                ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,  // code_unit[15:0]
    output logic                m_tlast
);

    logic [u8u16_pkg::MaxResults-1:0][u8u16_pkg::UnitW-1:0] units_reg, units_next;
    logic [u8u16_pkg::CntW-1:0]                           rem_reg, rem_next;
    logic                                                 fire;

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = units_reg[0];
    assign m_tlast  = (rem_reg == u8u16_pkg::CntW'(1));
    assign fire     = m_tvalid && m_tready;
    // free now, or the last word leaves this cycle
    assign ready    = (rem_reg == '0) || (m_tlast && m_tready);

    always_comb
    begin
        units_next = units_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            units_next = res.units;
            rem_next   = res.count;
        end
        else if (fire)
        begin
            units_next = {u8u16_pkg::UnitW'(0), units_reg[u8u16_pkg::MaxResults-1:1]};
            rem_next   = rem_reg - u8u16_pkg::CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        units_reg <= units_next;
    end

endmodule

FILE: hw/rtl/utf8_to_utf16_decoder_core.sv
// utf-8 to utf-16 decoder: an accepted byte's first word appears in the next cycle
// one byte per cycle while m_tready is high; a byte giving n words holds off input
// until its last word leaves; the result register drains one word a cycle on m_tready
// rst_n (async, active low) closes any open sequence and empties the result register
module utf8_to_utf16_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_unit[15:0]
    output logic        m_tlast    // last_of_run
);

`include "utf8_to_utf16_decoder_core_assert.svh"

    u8u16_pkg::dec_res_t res;
    logic                accept;

    assign accept = s_tvalid && s_tready;

    u8u16_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata),
        .end_of_text (s_tlast),
        .res         (res)
    );

    u8u16_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `U8U16_ASSERT(a_ready_only_on_last, (s_tready && m_tvalid) |-> (m_tlast && m_tready))
    `U8U16_ASSERT(a_silent_byte, (accept && (res.count == '0)) |=> !m_tvalid)
    `U8U16_ASSERT(a_run_continues, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    `U8U16_ASSERT_ALWAYS(a_count_bound, res.count <= u8u16_pkg::CntW'(u8u16_pkg::MaxResults))

endmodule

FILE: verif/utf8_to_utf16_decoder_core_tb.sv
// self-checking testbench for the utf-8 to utf-16 decoder core
module utf8_to_utf16_decoder_core_tb;

    localparam int ClkPeriod  = 20;
    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 10;

    typedef struct {
        u8u16_pkg::unit_t unit;
        logic             last;
    } utf16_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic        s_tlast;   // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // code_unit[15:0]
    logic        m_tlast;   // last_of_run

    // decoder sequence state as modelled by the predictor
    logic [1:0]  seq_need;
    logic [1:0]  seq_have;
    logic [20:0] seq_point;

    u8u16_pkg::unit_t step_units[$];
    utf16_word_t      expected_words[$];

    int src_idle_pct;
    int snk_idle_pct;
    int bytes_sent;
    int mismatch_count;
    int cycle_count;

    utf8_to_utf16_decoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(ClkPeriod / 2) clk = ~clk;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_unit(input u8u16_pkg::unit_t u);
        step_units.insert(step_units.size(), u);
    endfunction

    function automatic void emit_point(input logic [20:0] point);
        logic [20:0] offset;
        if (point <= u8u16_pkg::BmpMax)
        begin
            add_unit(point[15:0]);
        end
        else if (point <= u8u16_pkg::MaxPoint)
        begin
            offset = point - u8u16_pkg::PlaneBase;
            add_unit(u8u16_pkg::SurHi | u8u16_pkg::unit_t'(offset[19:10]));
            add_unit(u8u16_pkg::SurLo | u8u16_pkg::unit_t'(offset[9:0]));
        end
        else
        begin
            add_unit(u8u16_pkg::ReplChar);
        end
    endfunction

    // one replacement for the lead and one per continuation already taken
    function automatic void abandon_sequence();
        add_unit(u8u16_pkg::ReplChar);
        for (int k = 0; k < seq_have; k++)
        begin
            add_unit(u8u16_pkg::ReplChar);
        end
        seq_need  = 2'd0;
        seq_have  = 2'd0;
        seq_point = '0;
    endfunction

    function automatic void decode_lead(input logic [7:0] b, input logic eot);
        if (b[7] == 1'b0)
        begin
            add_unit(u8u16_pkg::unit_t'(b));
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            seq_point = 21'(b[4:0]);
            seq_need  = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            seq_point = 21'(b[3:0]);
            seq_need  = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            seq_point = 21'(b[2:0]);
            seq_need  = 2'd3;
        end
        else
        begin
            add_unit(u8u16_pkg::ReplChar);
            return;
        end
        seq_have = 2'd0;
        if (eot)
        begin
            abandon_sequence();
        end
    endfunction

    function automatic void predict_utf16(input logic [7:0] b, input logic eot);
        utf16_word_t w;
        step_units.delete();
        if (seq_need != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                seq_point = {seq_point[14:0], b[5:0]};
                seq_have  = seq_have + 2'd1;
                if (seq_have >= seq_need)
                begin
                    emit_point(seq_point);
                    seq_need  = 2'd0;
                    seq_have  = 2'd0;
                    seq_point = '0;
                end
                else if (eot)
                begin
                    abandon_sequence();
                end
            end
            else
            begin
                abandon_sequence();
                decode_lead(b, eot);
            end
        end
        else
        begin
            decode_lead(b, eot);
        end
        foreach (step_units[i])
        begin
            w.unit = step_units[i];
            w.last = (i == step_units.size() - 1);
            expected_words.insert(expected_words.size(), w);
        end
    endfunction

    // ----------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        utf16_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: code_unit %h last_of_run %b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want.unit)
                begin
                    $error("code_unit: expected %h, actual %h", want.unit, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_run: expected %b, actual %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ----------------------------------------------------------------- driving

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_utf16(b, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    // sender holds off until every outstanding word has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainWait) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // -------------------------------------------------------------------- tests

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);   // stray continuation as lead
        send_byte(8'hFF, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_well_formed();
        // overlong nul
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // top of the basic plane
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // surrogate pair
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // beyond the last code point
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_broken_sequences();
        // bad continuation, then the same byte decoded afresh
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // text ends on a lead
        send_byte(8'hC3, 1'b1);
        // four replacements from one byte
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'hF3, 1'b1);
        wait_for_drain();
    endtask

    task automatic send_random_sequence();
        int          kind;
        int          need;
        int          taken;
        logic [7:0]  lead;
        logic        end_here;
        kind     = $urandom_range(99);
        need     = $urandom_range(3, 1);
        end_here = ($urandom_range(7) == 0);
        unique case (need)
            1:       lead = 8'hC0 | 8'($urandom_range(31));
            2:       lead = 8'hE0 | 8'($urandom_range(15));
            default: lead = 8'hF0 | 8'($urandom_range(7));
        endcase
        if (kind < 15)
        begin
            send_byte(8'($urandom_range(127)), end_here);
        end
        else if (kind < 80)
        begin
            send_byte(lead, 1'b0);
            for (int k = 1; k <= need; k++)
            begin
                send_byte(rand_cont(), end_here && (k == need));
            end
        end
        else if (kind < 90)
        begin
            // cut short: ended by the text or broken by whatever follows
            taken = $urandom_range(need - 1);
            send_byte(lead, end_here && (taken == 0));
            for (int k = 1; k <= taken; k++)
            begin
                send_byte(rand_cont(), end_here && (k == taken));
            end
        end
        else
        begin
            send_byte(8'($urandom), end_here);
        end
    endtask

    task automatic test_random_text(input int count, input int src_pct, input int snk_pct);
        int first;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        first        = bytes_sent;
        while (bytes_sent - first < count)
        begin
            send_random_sequence();
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        seq_need       = 2'd0;
        seq_have       = 2'd0;
        seq_point      = '0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        bytes_sent     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_single_bytes();
        test_well_formed();
        test_broken_sequences();
        test_random_text(110, 20, 71);
        test_random_text(110, 71, 20);
        test_random_text(110, 0, 0);

        if (mismatch_count == 0 && expected_words.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_decode.sv
hw/rtl/u8u16_outbuf.sv
hw/rtl/utf8_to_utf16_decoder_core.sv
verif/utf8_to_utf16_decoder_core_tb.sv
